/* hw/rtl/asf_header_object_parser_assert.svh */
// Assertion macros for the header object parser.
`ifndef ASF_HEADER_OBJECT_PARSER_ASSERT_SVH
`define ASF_HEADER_OBJECT_PARSER_ASSERT_SVH

// Check that a condition holds at every clock edge outside reset.
`define ASF_HOP_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// Check that a trigger is followed by a consequence in the next cycle.
`define ASF_HOP_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/asf_hop_pkg.sv */
// Types, constants and codes shared by the header object parser.
package asf_hop_pkg;

  localparam int unsigned StreamTableDepthDefault = 20;

  localparam logic [4:0]  PrefixBytes  = 5'd30;
  localparam logic [63:0] HeadBytes    = 64'd24;
  localparam logic [63:0] PktLenAt     = 64'd92;
  localparam logic [63:0] StreamIdAt   = 64'd72;
  localparam logic [63:0] LenStartAt   = 64'd16;
  localparam logic [63:0] LenLastAt    = 64'd23;

  localparam logic [127:0] FileGuid   = {64'h6553200cc000e48e, 64'h11cfa9478cabdca1};
  localparam logic [127:0] StreamGuid = {64'h6553200cc000e68e, 64'h11cfa9b7b7dc0791};

  localparam logic [1:0] ObjUnknown = 2'd0;
  localparam logic [1:0] ObjFile    = 2'd1;
  localparam logic [1:0] ObjStream  = 2'd2;

  localparam logic [1:0] KindRecorded = 2'd0;
  localparam logic [1:0] KindSkipped  = 2'd1;
  localparam logic [1:0] KindSummary  = 2'd2;

  localparam int unsigned ResQueueDepth = 4;
  localparam int unsigned ResPtrW       = $clog2(ResQueueDepth);
  localparam int unsigned ResCountW     = $clog2(ResQueueDepth + 1);

  typedef struct packed {
    logic [7:0] header_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [15:0]        stream_ident;
    logic [4:0]         stream_count;
    logic signed [31:0] pkt_size;
    logic               malformed;
    logic               last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [1:0] num;
    out_item_t  first;
    out_item_t  second;
  } res_push_t;

  typedef struct packed {
    logic [4:0] prefix_left;
    logic       stopped;
  } parse_status_t;

endpackage

/* hw/rtl/asf_header_object_parser.sv */
// Top level of the header object parser: byte walk feeding a result queue.
//
//   channel | direction | payload                 | handshake
//   in      | input     | in_item_i (in_item_t)   | in_valid_i / in_stall_o
//   out     | output    | out_item_o (out_item_t) | out_valid_o / out_stall_i
//
// One header byte is taken per cycle while in_stall_o is low; its results enter the queue at the accepting edge.
// A result shows on out_valid_o from the cycle after its byte is accepted.
// A byte gives up to two results, the queue drains one per cycle while out_stall_i is low.
// in_stall_o rises only when the result queue holds more than two results.
// Asynchronous active-low reset returns to the start of a header.
module asf_header_object_parser #(
  parameter int unsigned StreamTableDepth = asf_hop_pkg::StreamTableDepthDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  asf_hop_pkg::in_item_t  in_item_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output asf_hop_pkg::out_item_t out_item_o
);
  import asf_hop_pkg::*;

  logic                 in_acc;
  res_push_t            push;
  parse_status_t        status;
  logic                 full;
  logic [ResCountW-1:0] count;
  logic                 fin_acc;
  logic                 rearmed;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = full;
  assign fin_acc    = in_acc && in_item_i.final_byte;
  assign rearmed    = (status.prefix_left == PrefixBytes) && !status.stopped;

  asf_hop_parse #(
    .StreamTableDepth(StreamTableDepth)
  ) u_parse (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(in_acc),
    .item_i  (in_item_i),
    .push_o  (push),
    .status_o(status)
  );

  asf_hop_resq u_resq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (!out_stall_i),
    .valid_o(out_valid_o),
    .item_o (out_item_o),
    .full_o (full),
    .count_o(count)
  );

`include "asf_header_object_parser_assert.svh"

  `ASF_HOP_ASSERT(a_queue_bound, count <= ResCountW'(ResQueueDepth), "result queue overflow")
  `ASF_HOP_ASSERT_NEXT(a_final_summary, fin_acc, out_valid_o, "no summary queued")
  `ASF_HOP_ASSERT_NEXT(a_final_rearm, fin_acc, rearmed, "parser not rearmed after final byte")

endmodule

/* hw/rtl/asf_hop_parse.sv */
// Per-byte header walk: object offset, GUID match, length, packet length and stream ids.
module asf_hop_parse #(
  parameter int unsigned StreamTableDepth = asf_hop_pkg::StreamTableDepthDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  asf_hop_pkg::in_item_t     item_i,
  output asf_hop_pkg::res_push_t    push_o,
  output asf_hop_pkg::parse_status_t status_o
);
  import asf_hop_pkg::*;

  logic [4:0]  prefix_q, prefix_d;
  logic [63:0] off_q, off_d;
  logic [63:0] len_q, len_d;
  logic        mfile_q, mfile_d;
  logic        mstream_q, mstream_d;
  logic [1:0]  obj_q, obj_d;
  logic [31:0] pkt_q, pkt_d;
  logic [4:0]  streams_q, streams_d;
  logic [7:0]  sid_low_q, sid_low_d;
  logic        stopped_q, stopped_d;

  logic [7:0]  b;
  logic        adv;
  logic [63:0] off_inc;
  logic [63:0] len_eff;
  logic [63:0] len_full;
  logic        stream_emit;
  logic [1:0]  stream_kind;
  logic [15:0] sid;
  out_item_t   stream_res;
  out_item_t   summary_res;

  assign b        = item_i.header_byte;
  assign off_inc  = off_q + 64'd1;
  assign len_full = {b, len_q[55:0]};

  always_comb begin
    prefix_d    = prefix_q;
    off_d       = off_q;
    len_d       = len_q;
    mfile_d     = mfile_q;
    mstream_d   = mstream_q;
    obj_d       = obj_q;
    pkt_d       = pkt_q;
    streams_d   = streams_q;
    sid_low_d   = sid_low_q;
    stopped_d   = stopped_q;
    adv         = 1'b0;
    len_eff     = len_q;
    stream_emit = 1'b0;
    stream_kind = KindRecorded;
    sid         = {b, sid_low_q};
    if (!stopped_q) begin
      if (prefix_q != 5'd0) begin
        prefix_d = prefix_q - 5'd1;
      end else begin
        adv = 1'b1;
        if (off_q < LenStartAt) begin
          mfile_d   = ((off_q[3:0] == 4'd0) | mfile_q) &
                      (b == FileGuid[{off_q[3:0], 3'b000} +: 8]);
          mstream_d = ((off_q[3:0] == 4'd0) | mstream_q) &
                      (b == StreamGuid[{off_q[3:0], 3'b000} +: 8]);
          if (off_q == 64'd0) begin
            obj_d = ObjUnknown;
          end
        end else if (off_q < LenLastAt) begin
          len_d[{off_q[2:0], 3'b000} +: 8] = b;
        end else if (off_q == LenLastAt) begin
          len_d   = len_full;
          len_eff = len_full;
          if (len_full < HeadBytes) begin
            stopped_d = 1'b1;
            adv       = 1'b0;
          end else if (mfile_q) begin
            obj_d = ObjFile;
          end else if (mstream_q) begin
            obj_d = ObjStream;
          end else begin
            obj_d = ObjUnknown;
          end
        end else if (obj_q == ObjFile) begin
          if (off_q == PktLenAt) begin
            pkt_d = {24'd0, b};
          end else if (off_q > PktLenAt && off_q < PktLenAt + 64'd4) begin
            pkt_d[{off_q[1:0], 3'b000} +: 8] = b;
          end
        end else if (obj_q == ObjStream) begin
          if (off_q == StreamIdAt) begin
            sid_low_d = b;
          end else if (off_q == StreamIdAt + 64'd1) begin
            stream_emit = 1'b1;
            if (streams_q < 5'(StreamTableDepth)) begin
              streams_d   = streams_q + 5'd1;
              stream_kind = KindRecorded;
            end else begin
              stream_kind = KindSkipped;
            end
          end
        end
        if (adv) begin
          off_d = (off_inc >= HeadBytes && off_inc == len_eff) ? 64'd0 : off_inc;
        end
      end
    end
  end

  always_comb begin
    stream_res.kind          = stream_kind;
    stream_res.stream_ident  = sid;
    stream_res.stream_count  = streams_d;
    stream_res.pkt_size      = pkt_d;
    stream_res.malformed     = 1'b0;
    stream_res.last_of_run   = !item_i.final_byte;

    summary_res.kind          = KindSummary;
    summary_res.stream_ident  = 16'd0;
    summary_res.stream_count  = streams_d;
    summary_res.pkt_size      = pkt_d;
    summary_res.malformed     = stopped_d;
    summary_res.last_of_run   = 1'b1;

    push_o.num    = 2'd0;
    push_o.first  = stream_emit ? stream_res : summary_res;
    push_o.second = summary_res;
    if (accept_i) begin
      push_o.num = 2'({1'b0, stream_emit} + {1'b0, item_i.final_byte});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q  <= PrefixBytes;
      off_q     <= 64'd0;
      len_q     <= 64'd0;
      mfile_q   <= 1'b0;
      mstream_q <= 1'b0;
      obj_q     <= ObjUnknown;
      pkt_q     <= '1;
      streams_q <= 5'd0;
      sid_low_q <= 8'd0;
      stopped_q <= 1'b0;
    end else if (accept_i) begin
      if (item_i.final_byte) begin
        prefix_q  <= PrefixBytes;
        off_q     <= 64'd0;
        len_q     <= 64'd0;
        mfile_q   <= 1'b0;
        mstream_q <= 1'b0;
        obj_q     <= ObjUnknown;
        pkt_q     <= '1;
        streams_q <= 5'd0;
        sid_low_q <= 8'd0;
        stopped_q <= 1'b0;
      end else begin
        prefix_q  <= prefix_d;
        off_q     <= off_d;
        len_q     <= len_d;
        mfile_q   <= mfile_d;
        mstream_q <= mstream_d;
        obj_q     <= obj_d;
        pkt_q     <= pkt_d;
        streams_q <= streams_d;
        sid_low_q <= sid_low_d;
        stopped_q <= stopped_d;
      end
    end
  end

  assign status_o.prefix_left = prefix_q;
  assign status_o.stopped     = stopped_q;

endmodule

/* hw/rtl/asf_hop_resq.sv */
// Result queue: takes up to two results per cycle, hands out one per cycle while pop_i is high.
module asf_hop_resq (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  asf_hop_pkg::res_push_t              push_i,
  input  logic                                pop_i,
  output logic                                valid_o,
  output asf_hop_pkg::out_item_t              item_o,
  output logic                                full_o,
  output logic [asf_hop_pkg::ResCountW-1:0]   count_o
);
  import asf_hop_pkg::*;

  out_item_t            mem_q [ResQueueDepth];
  logic [ResPtrW-1:0]   wr_q, rd_q;
  logic [ResCountW-1:0] count_q;
  logic                 pop;

  assign pop     = pop_i && (count_q != '0);
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_q];
  assign full_o  = (count_q > ResCountW'(ResQueueDepth - 2));
  assign count_o = count_q;

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_q] <= push_i.first;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_q + ResPtrW'(1)] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_q + ResPtrW'(push_i.num);
      rd_q    <= rd_q + ResPtrW'(pop);
      count_q <= count_q + ResCountW'(push_i.num) - ResCountW'(pop);
    end
  end

endmodule
